// ===== sv/assert_macros.svh =====
// Assertion macros shared by the attitude estimator RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IMUCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IMUCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/imuca_pkg.sv =====
// Types, constants and command tables for the IMU attitude estimator.
// No dependencies; used by the controller, the datapath and the top level.
package imuca_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AngleFracDef   = 16;
  localparam int unsigned StepW = 5;   // CORDIC step index, table has 24 entries
  localparam int unsigned JobW  = 4;
  localparam int unsigned XW    = 36;  // CORDIC x/y width
  localparam int unsigned ZW    = 33;  // CORDIC angle accumulator, Q24 degrees
  localparam int unsigned VW    = 39;  // multiplier A operand before splitting
  localparam int unsigned CW    = 19;  // low chunk width of the A operand
  localparam int unsigned BW    = 32;
  localparam int unsigned PW    = 52;
  localparam int unsigned AW    = 72;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 25;

  localparam logic signed [BW-1:0] InvGainQ30 = 32'sd652032874;
  localparam logic signed [BW-1:0] AlphaQ24   = 32'sd16106127;
  localparam logic signed [BW-1:0] BetaQ24    = 32'sd671089;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pitch_deg;
    logic signed [31:0] roll_deg;
    logic signed [31:0] yaw_deg;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GYRO_RANGE  = 3'd0,
    REG_ACCEL_RANGE = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3,
    REG_OFFSET_Z    = 3'd4,
    REG_STEP_TIME   = 3'd5,
    REG_YAW_GAIN    = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL_LO, OP_ACC_LO, OP_ACC_HI, OP_STORE, OP_CORDIC, OP_SEED, OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    A_DX, A_DY, A_DZ, A_WX, A_WY, A_WZ, A_X0, A_X1, A_SP, A_SR, A_TP, A_TR
  } asel_e;

  typedef enum logic [2:0] {
    B_RECIP, B_STEP, B_YAW, B_INV, B_ALPHA, B_BETA
  } bsel_e;

  typedef enum logic [1:0] {
    BASE_ZERO, BASE_RND, BASE_HALF, BASE_ACC
  } base_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_WX, DST_WY, DST_WZ, DST_INC_R, DST_INC_P, DST_YAW,
    DST_MAG0, DST_MAG1, DST_PITCH, DST_ROLL
  } dst_e;

  typedef struct packed {
    asel_e asel;
    bsel_e bsel;
    base_e base;
    dst_e  dst;
  } job_t;

  typedef struct packed {
    dp_op_e           op;
    job_t             job;
    logic [StepW-1:0] step;
  } cmd_t;

  // Job indexes that the controller branches on.
  localparam logic [JobW-1:0] JobLastRate = 4'd5;
  localparam logic [JobW-1:0] JobLastMag  = 4'd7;
  localparam logic [JobW-1:0] JobLast     = 4'd11;

  function automatic job_t job_cmd(input logic [JobW-1:0] j);
    job_t r;
    case (j)
      4'd0:    r = '{A_DX, B_RECIP, BASE_ZERO, DST_WX};
      4'd1:    r = '{A_DY, B_RECIP, BASE_ZERO, DST_WY};
      4'd2:    r = '{A_DZ, B_RECIP, BASE_ZERO, DST_WZ};
      4'd3:    r = '{A_WX, B_STEP,  BASE_RND,  DST_INC_R};
      4'd4:    r = '{A_WY, B_STEP,  BASE_RND,  DST_INC_P};
      4'd5:    r = '{A_WZ, B_YAW,   BASE_RND,  DST_YAW};
      4'd6:    r = '{A_X0, B_INV,   BASE_ZERO, DST_MAG0};
      4'd7:    r = '{A_X1, B_INV,   BASE_ZERO, DST_MAG1};
      4'd8:    r = '{A_SP, B_ALPHA, BASE_HALF, DST_NONE};
      4'd9:    r = '{A_TP, B_BETA,  BASE_ACC,  DST_PITCH};
      4'd10:   r = '{A_SR, B_ALPHA, BASE_HALF, DST_NONE};
      4'd11:   r = '{A_TR, B_BETA,  BASE_ACC,  DST_ROLL};
      default: r = '{A_DX, B_RECIP, BASE_ZERO, DST_NONE};
    endcase
    return r;
  endfunction

  // atan(2^-i) in Q24 degrees.
  function automatic logic signed [31:0] atan_q24(input logic [StepW-1:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd754974720;
      5'd1:  r = 32'sd445687602;
      5'd2:  r = 32'sd235489088;
      5'd3:  r = 32'sd119537938;
      5'd4:  r = 32'sd60000934;
      5'd5:  r = 32'sd30029717;
      5'd6:  r = 32'sd15018523;
      5'd7:  r = 32'sd7509720;
      5'd8:  r = 32'sd3754917;
      5'd9:  r = 32'sd1877466;
      5'd10: r = 32'sd938734;
      5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;
      5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;
      5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;
      5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;
      5'd19: r = 32'sd1833;
      5'd20: r = 32'sd917;
      5'd21: r = 32'sd458;
      5'd22: r = 32'sd229;
      5'd23: r = 32'sd115;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Reciprocal gyro sensitivity in Q24 (deg/s per LSB).
  function automatic logic [20:0] gyro_recip(input logic [1:0] rng);
    logic [20:0] r;
    case (rng)
      2'd0:    r = 21'd128070;
      2'd1:    r = 21'd256141;
      2'd2:    r = 21'd511500;
      2'd3:    r = 21'd1023001;
      default: r = 21'd128070;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/imuca_ctrl.sv =====
// Sequencer for the attitude estimator: steps the datapath through the
// multiply jobs and CORDIC passes. Depends on imuca_pkg.
module imuca_ctrl #(
  parameter int unsigned CORDIC_STEPS = imuca_pkg::CordicStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output imuca_pkg::cmd_t   cmd_o
);
  import imuca_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_MLO    = 8'b00000010,
    S_ALO    = 8'b00000100,
    S_AHI    = 8'b00001000,
    S_STORE  = 8'b00010000,
    S_CORDIC = 8'b00100000,
    S_SEED   = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_e;

  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  state_e           state_q, state_d;
  logic [JobW-1:0]  job_q, job_d;
  logic [StepW-1:0] step_q, step_d;
  logic             pass_q, pass_d;
  logic             first_q, first_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    step_d      = step_q;
    pass_d      = pass_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NOP;
    cmd_o.job   = job_cmd(job_q);
    cmd_o.step  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          job_d    = '0;
          state_d  = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = S_ALO;
      end
      S_ALO: begin
        cmd_o.op = OP_ACC_LO;
        state_d  = S_AHI;
      end
      S_AHI: begin
        cmd_o.op = OP_ACC_HI;
        state_d  = S_STORE;
      end
      S_STORE: begin
        cmd_o.op = OP_STORE;
        job_d    = job_q + 1'b1;
        if (job_q == JobLastRate) begin
          step_d  = '0;
          pass_d  = 1'b0;
          state_d = S_CORDIC;
        end else if (job_q == JobLastMag) begin
          step_d  = '0;
          pass_d  = 1'b1;
          state_d = S_CORDIC;
        end else if (job_q == JobLast) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_MLO;
        end
      end
      S_CORDIC: begin
        cmd_o.op = OP_CORDIC;
        step_d   = step_q + 1'b1;
        if (step_q == LastStep) begin
          if (!pass_q) begin
            state_d = S_MLO;
          end else if (first_q) begin
            state_d = S_SEED;
          end else begin
            state_d = S_MLO;
          end
        end
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        first_d  = 1'b0;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      step_q      <= '0;
      pass_q      <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/imuca_dp.sv =====
// Datapath of the attitude estimator: configuration registers, shared
// multiply-accumulate unit, two CORDIC lanes and the angle state. Depends on imuca_pkg.
module imuca_dp #(
  parameter int unsigned ANGLE_FRAC_BITS = imuca_pkg::AngleFracDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [imuca_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [imuca_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  imuca_pkg::in_item_t                  in_data_i,
  input  imuca_pkg::cmd_t                      cmd_i,
  output imuca_pkg::out_item_t                 out_data_o
);
  import imuca_pkg::*;

  localparam int unsigned Sh = 48 - ANGLE_FRAC_BITS;
  localparam int unsigned Rs = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] RndBias  = AW'(1) << (Sh - 1);
  localparam logic signed [AW-1:0] HalfBias = AW'(1) << 23;
  localparam logic signed [ZW-1:0] TiltBias = ZW'(1) << (Rs - 1);
  localparam logic signed [AW-1:0] SatMax   = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] SatMin   = -AW'(64'sd2147483648);

  // Configuration.
  logic [1:0]         gyro_range_q;
  logic [1:0]         accel_range_q;
  logic signed [15:0] off_q [3];
  logic [23:0]        step_time_q;
  logic signed [24:0] yaw_gain_q;

  // Per-item working registers.
  logic signed [16:0]   d_q   [3];
  logic signed [VW-1:0] w_q   [3];
  logic signed [XW-1:0] inc_q [2];  // lane 0 pitch, lane 1 roll
  logic signed [15:0]   n_q   [2];
  logic signed [XW-1:0] x_q   [2];
  logic signed [XW-1:0] y_q   [2];
  logic signed [ZW-1:0] z_q   [2];
  logic                 zero_q[2];
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;

  // Estimator state.
  logic signed [31:0] est_q [2];
  logic [31:0]        yaw_q;
  out_item_t          out_q;

  logic signed [VW-1:0] a_v;
  logic signed [BW-1:0] b_v;
  logic signed [19:0]   a_lo, a_hi;
  logic signed [AW-1:0] base_v, acc_sh, acc_blend, acc_mag;
  logic signed [31:0]   tilt_v [2];
  logic signed [XW-1:0] s_v    [2];
  logic signed [XW-1:0] mag_v;
  logic signed [31:0]   sat_v;
  logic [16:0]          abs_ax, abs_ay, abs_az;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s_v[l]    = XW'(est_q[l]) + inc_q[l];
      tilt_v[l] = zero_q[l] ? 32'sd0 : 32'((z_q[l] + TiltBias) >>> Rs);
    end
    abs_ax = abs16(in_data_i.accel_x);
    abs_ay = abs16(in_data_i.accel_y);
    abs_az = abs16(in_data_i.accel_z);
  end

  always_comb begin
    case (cmd_i.job.asel)
      A_DX:    a_v = VW'(d_q[0]);
      A_DY:    a_v = VW'(d_q[1]);
      A_DZ:    a_v = VW'(d_q[2]);
      A_WX:    a_v = w_q[0];
      A_WY:    a_v = w_q[1];
      A_WZ:    a_v = w_q[2];
      A_X0:    a_v = VW'(x_q[0]);
      A_X1:    a_v = VW'(x_q[1]);
      A_SP:    a_v = VW'(s_v[0]);
      A_SR:    a_v = VW'(s_v[1]);
      A_TP:    a_v = VW'(tilt_v[0]);
      A_TR:    a_v = VW'(tilt_v[1]);
      default: a_v = '0;
    endcase
    case (cmd_i.job.bsel)
      B_RECIP: b_v = BW'($signed({1'b0, gyro_recip(gyro_range_q)}));
      B_STEP:  b_v = BW'($signed({1'b0, step_time_q}));
      B_YAW:   b_v = BW'(yaw_gain_q);
      B_INV:   b_v = InvGainQ30;
      B_ALPHA: b_v = AlphaQ24;
      B_BETA:  b_v = BetaQ24;
      default: b_v = '0;
    endcase
    case (cmd_i.job.base)
      BASE_ZERO: base_v = '0;
      BASE_RND:  base_v = RndBias;
      BASE_HALF: base_v = HalfBias;
      BASE_ACC:  base_v = acc_q;
      default:   base_v = '0;
    endcase
    a_lo = $signed({1'b0, a_v[CW-1:0]});
    a_hi = a_v[VW-1:CW];
  end

  always_comb begin
    acc_sh    = acc_q >>> Sh;
    acc_blend = acc_q >>> 24;
    acc_mag   = acc_q >>> 30;
    mag_v     = acc_mag[XW-1:0];
    if (acc_blend > SatMax) begin
      sat_v = 32'sh7fffffff;
    end else if (acc_blend < SatMin) begin
      sat_v = 32'sh80000000;
    end else begin
      sat_v = acc_blend[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_range_q  <= 2'd0;
      accel_range_q <= 2'd0;
      off_q[0]      <= '0;
      off_q[1]      <= '0;
      off_q[2]      <= '0;
      step_time_q   <= 24'd83886;
      yaw_gain_q    <= 25'sd83886;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GYRO_RANGE:  gyro_range_q  <= cfg_wdata_i[1:0];
        REG_ACCEL_RANGE: accel_range_q <= cfg_wdata_i[1:0];
        REG_OFFSET_X:    off_q[0]      <= cfg_wdata_i[15:0];
        REG_OFFSET_Y:    off_q[1]      <= cfg_wdata_i[15:0];
        REG_OFFSET_Z:    off_q[2]      <= cfg_wdata_i[15:0];
        REG_STEP_TIME:   step_time_q   <= cfg_wdata_i[23:0];
        REG_YAW_GAIN:    yaw_gain_q    <= cfg_wdata_i[24:0];
        default: ;
      endcase
    end
  end

  // State registers of the estimator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q[0] <= '0;
      est_q[1] <= '0;
      yaw_q    <= '0;
    end else begin
      if (cmd_i.op == OP_STORE) begin
        case (cmd_i.job.dst)
          DST_YAW:   yaw_q    <= yaw_q + acc_sh[31:0];
          DST_PITCH: est_q[0] <= sat_v;
          DST_ROLL:  est_q[1] <= sat_v;
          default: ;
        endcase
      end else if (cmd_i.op == OP_SEED) begin
        est_q[0] <= tilt_v[0];
        est_q[1] <= tilt_v[1];
      end
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        d_q[0] <= {in_data_i.rate_x[15], in_data_i.rate_x} - {off_q[0][15], off_q[0]};
        d_q[1] <= {in_data_i.rate_y[15], in_data_i.rate_y} - {off_q[1][15], off_q[1]};
        d_q[2] <= {in_data_i.rate_z[15], in_data_i.rate_z} - {off_q[2][15], off_q[2]};
        n_q[0] <= in_data_i.accel_y;
        n_q[1] <= in_data_i.accel_x;
        x_q[0] <= $signed(XW'({abs_az, 16'b0}));
        x_q[1] <= $signed(XW'({abs_az, 16'b0}));
        y_q[0] <= $signed(XW'({abs_ax, 16'b0}));
        y_q[1] <= $signed(XW'({abs_ay, 16'b0}));
        z_q[0] <= '0;
        z_q[1] <= '0;
      end
      OP_MUL_LO: prod_q <= PW'(a_lo * b_v);
      OP_ACC_LO: begin
        acc_q  <= base_v + AW'(prod_q);
        prod_q <= PW'(a_hi * b_v);
      end
      OP_ACC_HI: acc_q <= acc_q + (AW'(prod_q) <<< CW);
      OP_STORE: begin
        case (cmd_i.job.dst)
          DST_WX:    w_q[0]   <= acc_q[VW-1:0];
          DST_WY:    w_q[1]   <= acc_q[VW-1:0];
          DST_WZ:    w_q[2]   <= acc_q[VW-1:0];
          DST_INC_P: inc_q[0] <= acc_sh[XW-1:0];
          DST_INC_R: inc_q[1] <= acc_sh[XW-1:0];
          DST_MAG0: begin
            x_q[0]    <= mag_v;
            y_q[0]    <= {{4{n_q[0][15]}}, n_q[0], 16'b0};
            z_q[0]    <= '0;
            zero_q[0] <= (mag_v == '0) && (n_q[0] == '0);
          end
          DST_MAG1: begin
            x_q[1]    <= mag_v;
            y_q[1]    <= {{4{n_q[1][15]}}, n_q[1], 16'b0};
            z_q[1]    <= '0;
            zero_q[1] <= (mag_v == '0) && (n_q[1] == '0);
          end
          default: ;
        endcase
      end
      OP_CORDIC: begin
        for (int l = 0; l < 2; l++) begin
          // A non-negative y rotates the vector down.
          if (!y_q[l][XW-1]) begin
            x_q[l] <= x_q[l] + (y_q[l] >>> cmd_i.step);
            y_q[l] <= y_q[l] - (x_q[l] >>> cmd_i.step);
            z_q[l] <= z_q[l] + ZW'(atan_q24(cmd_i.step));
          end else begin
            x_q[l] <= x_q[l] - (y_q[l] >>> cmd_i.step);
            y_q[l] <= y_q[l] + (x_q[l] >>> cmd_i.step);
            z_q[l] <= z_q[l] - ZW'(atan_q24(cmd_i.step));
          end
        end
      end
      OP_OUT: begin
        out_q.pitch_deg <= est_q[0];
        out_q.roll_deg  <= est_q[1];
        out_q.yaw_deg   <= yaw_q;
      end
      default: ;
    endcase
  end

  // The accelerometer range cancels in the tilt angles; it is only held.
  logic accel_range_unused;
  assign accel_range_unused = ^accel_range_q;

  assign out_data_o = out_q;

endmodule

// ===== sv/imu_complementary_attitude_top.sv =====
// Complementary-filter attitude estimator, top level. Depends on imuca_pkg.
// One sample at a time, set by the single shared multiplier and the CORDIC iterations;
// a finished sample waits while the output register is full. The first sample after reset
// seeds the angles from the accelerometer tilt instead of blending.
// Reset (asynchronous, active low) zeroes the angles and re-arms seeding.
module imu_complementary_attitude_top #(
  parameter int unsigned CORDIC_STEPS    = imuca_pkg::CordicStepsDef,
  parameter int unsigned ANGLE_FRAC_BITS = imuca_pkg::AngleFracDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [imuca_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [imuca_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  imuca_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output imuca_pkg::out_item_t           out_data_o
);
  import imuca_pkg::*;

  cmd_t cmd;

  imuca_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  imuca_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

`include "assert_macros.svh"

  `IMUCA_ASSERT_IMP(a_load_on_accept, cmd.op == OP_LOAD, in_valid_i && in_ready_o, "load without an accepted transaction")
  `IMUCA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accepting a transaction")
  `IMUCA_ASSERT_IMP(a_out_slot_free, cmd.op == OP_OUT, !out_valid_o || out_ready_i, "result overwrites a pending transaction")

endmodule
